@@ rtl/grc_pkg.sv @@
// grc_pkg: shared types and codes for the grid ray caster.
// Holds controller states, command/status structs, face and mode codes.
// No dependencies.
package grc_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK0,
      ST_LOOK1,
      ST_LOOK2,
      ST_WAIT0,
      ST_WAIT1,
      ST_DECIDE,
      ST_ABS,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      LOOK_CUR,
      LOOK_PX,
      LOOK_PY
   } look_type;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CAST  = 1'b1;

   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_WEST  = 3'd1;
   localparam logic [2:0] FACE_EAST  = 3'd2;
   localparam logic [2:0] FACE_SOUTH = 3'd3;
   localparam logic [2:0] FACE_NORTH = 3'd4;

   typedef struct packed {
      logic     clear;
      logic     cell_write;
      logic     load;
      logic     look_en;
      look_type look_tag;
      logic     step;
      logic     set_nohit;
      logic     abs_diff;
      logic     sq_x;
      logic     root_init;
      logic     root_step;
      logic     mul;
      logic     div_step;
      logic     publish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic cur_wall;
      logic steps_max;
      logic rsp_busy;
   } status_type;

endpackage

@@ rtl/grc_ctrl.sv @@
// grc_ctrl: sequencer for map clear, ray march, distance and height.
// Depends on grc_pkg; drives grc_datapath through cmd_type.
module grc_ctrl #(
   parameter int ROOT_W = 30,
   parameter int DIV_W  = 41
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  grc_pkg::status_type status,
   output grc_pkg::cmd_type    cmd
);

   localparam int ITER_MAX = (ROOT_W > DIV_W) ? ROOT_W : DIV_W;
   localparam int ITER_W   = $clog2(ITER_MAX + 1);

   grc_pkg::state_type state_ff, state_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grc_pkg::ST_CLEAR;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         grc_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = grc_pkg::ST_IDLE;
         end
         grc_pkg::ST_IDLE: begin
            if (req_valid && req_mode == grc_pkg::MODE_CAST) state_in = grc_pkg::ST_LOOK0;
         end
         grc_pkg::ST_LOOK0: state_in = grc_pkg::ST_LOOK1;
         grc_pkg::ST_LOOK1: state_in = grc_pkg::ST_LOOK2;
         grc_pkg::ST_LOOK2: state_in = grc_pkg::ST_WAIT0;
         grc_pkg::ST_WAIT0: state_in = grc_pkg::ST_WAIT1;
         grc_pkg::ST_WAIT1: state_in = grc_pkg::ST_DECIDE;
         grc_pkg::ST_DECIDE: begin
            if (status.cur_wall || status.steps_max) state_in = grc_pkg::ST_ABS;
            else state_in = grc_pkg::ST_LOOK0;
         end
         grc_pkg::ST_ABS: state_in = grc_pkg::ST_SQX;
         grc_pkg::ST_SQX: state_in = grc_pkg::ST_SQY;
         grc_pkg::ST_SQY: begin
            state_in = grc_pkg::ST_ROOT;
            iter_in  = '0;
         end
         grc_pkg::ST_ROOT: begin
            if (iter_ff == ITER_W'(ROOT_W - 1)) state_in = grc_pkg::ST_MUL;
            else iter_in = iter_ff + 1'b1;
         end
         grc_pkg::ST_MUL: begin
            state_in = grc_pkg::ST_DIV;
            iter_in  = '0;
         end
         grc_pkg::ST_DIV: begin
            if (iter_ff == ITER_W'(DIV_W - 1)) state_in = grc_pkg::ST_OUT;
            else iter_in = iter_ff + 1'b1;
         end
         grc_pkg::ST_OUT: begin
            if (!status.rsp_busy) state_in = grc_pkg::ST_IDLE;
         end
         default: state_in = grc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff) inside
         grc_pkg::ST_CLEAR: cmd.clear = 1'b1;
         grc_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.cell_write = req_valid && req_mode == grc_pkg::MODE_WRITE;
            cmd.load       = req_valid && req_mode == grc_pkg::MODE_CAST;
         end
         grc_pkg::ST_LOOK0: begin
            cmd.look_en  = 1'b1;
            cmd.look_tag = grc_pkg::LOOK_CUR;
         end
         grc_pkg::ST_LOOK1: begin
            cmd.look_en  = 1'b1;
            cmd.look_tag = grc_pkg::LOOK_PX;
         end
         grc_pkg::ST_LOOK2: begin
            cmd.look_en  = 1'b1;
            cmd.look_tag = grc_pkg::LOOK_PY;
         end
         grc_pkg::ST_WAIT0, grc_pkg::ST_WAIT1: ;
         grc_pkg::ST_DECIDE: begin
            cmd.step      = !status.cur_wall && !status.steps_max;
            cmd.set_nohit = !status.cur_wall && status.steps_max;
         end
         grc_pkg::ST_ABS:  cmd.abs_diff  = 1'b1;
         grc_pkg::ST_SQX:  cmd.sq_x      = 1'b1;
         grc_pkg::ST_SQY:  cmd.root_init = 1'b1;
         grc_pkg::ST_ROOT: cmd.root_step = 1'b1;
         grc_pkg::ST_MUL:  cmd.mul       = 1'b1;
         grc_pkg::ST_DIV:  cmd.div_step  = 1'b1;
         grc_pkg::ST_OUT:  cmd.publish   = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

@@ rtl/grc_datapath.sv @@
// grc_datapath: ray position, wall map memory, cell lookup pipeline,
// square root and divide units, result register. Depends on grc_pkg.
module grc_datapath #(
   parameter int CELL_SIZE = 64,
   parameter int SCREEN_H  = 512,
   parameter int MAP_W     = 64,
   parameter int MAP_H     = 64,
   parameter int MAX_STEPS = 8192,
   parameter int ROOT_W    = 30,
   parameter int DIV_W     = 41
) (
   input  logic                clock,
   input  logic                reset,
   input  grc_pkg::cmd_type    cmd,
   output grc_pkg::status_type status,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [19:0]         csr_wdata,
   input  logic [5:0]          req_cell_col,
   input  logic [5:0]          req_cell_row,
   input  logic                req_cell_is_wall,
   input  logic [9:0]          req_column,
   input  logic signed [15:0]  req_step_x,
   input  logic signed [15:0]  req_step_y,
   input  logic [14:0]         req_view_cos,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [9:0]          rsp_out_column,
   output logic [19:0]         rsp_hit_x,
   output logic [19:0]         rsp_hit_y,
   output logic [2:0]          rsp_face,
   output logic [20:0]         rsp_distance,
   output logic [15:0]         rsp_wall_height,
   output logic [8:0]          rsp_span_start,
   output logic [8:0]          rsp_span_end,
   output logic                rsp_no_hit
);

   localparam int STEP_LOG = $clog2(MAX_STEPS);
   localparam int POS_W    = ((STEP_LOG + 15 > 26) ? STEP_LOG + 15 : 26) + 2;
   localparam int PIX_W    = POS_W - 14;
   localparam int DIFF_W   = STEP_LOG + 16;
   localparam int SUM_W    = 2 * DIFF_W + 1;
   localparam int STEP_W   = $clog2(MAX_STEPS + 1);
   localparam int DEPTH    = MAP_W * MAP_H;
   localparam int AW       = $clog2(DEPTH);
   localparam int CX_W     = $clog2(MAP_W);
   localparam int CY_W     = $clog2(MAP_H);
   localparam int PROD_W   = 49;
   localparam int REAL_W   = 36;
   localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(CELL_SIZE) - 64'd1)
                                       / 64'(CELL_SIZE));
   localparam logic [31:0] LIM_X = 32'(MAP_W * CELL_SIZE);
   localparam logic [31:0] LIM_Y = 32'(MAP_H * CELL_SIZE);
   localparam logic [DIV_W-1:0] NUM = DIV_W'(CELL_SIZE * SCREEN_H) << 22;
   localparam int HALF = SCREEN_H / 2;

   // configuration
   logic [19:0] origin_x_ff, origin_y_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == grc_pkg::CSR_ORIGIN_X) origin_x_ff <= csr_wdata;
         else origin_y_ff <= csr_wdata;
      end
   end

   // request latch and march state
   logic [9:0]               column_ff;
   logic signed [15:0]       dx_ff, dy_ff;
   logic [14:0]              vc_ff;
   logic signed [POS_W-1:0]  x_ff, y_ff, ox, oy;
   logic [STEP_W-1:0]        steps_ff;
   logic                     probe_x_ff, probe_y_ff, nohit_ff;
   logic                     px_wall_ff, py_wall_ff;

   assign ox = POS_W'({origin_x_ff, 6'b0});
   assign oy = POS_W'({origin_y_ff, 6'b0});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         column_ff  <= req_column;
         dx_ff      <= req_step_x;
         dy_ff      <= req_step_y;
         vc_ff      <= req_view_cos;
         x_ff       <= ox;
         y_ff       <= oy;
         steps_ff   <= '0;
         probe_x_ff <= 1'b0;
         probe_y_ff <= 1'b0;
         nohit_ff   <= 1'b0;
      end else if (cmd.step) begin
         x_ff       <= x_ff - POS_W'(dx_ff);
         y_ff       <= y_ff - POS_W'(dy_ff);
         steps_ff   <= steps_ff + 1'b1;
         probe_x_ff <= probe_x_ff | px_wall_ff;
         probe_y_ff <= probe_y_ff | py_wall_ff;
      end else if (cmd.set_nohit) begin
         nohit_ff <= 1'b1;
      end
   end

   // wall map memory with clear sweep
   logic              map_mem [DEPTH];
   logic [AW-1:0]     clr_ff;
   logic              wr_en, wr_data, rd_q_ff;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              cell_in_range;

   assign cell_in_range = 32'(req_cell_col) < 32'(MAP_W) && 32'(req_cell_row) < 32'(MAP_H);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = 1'b0;
      wr_addr = clr_ff;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.cell_write && cell_in_range) begin
         wr_en   = 1'b1;
         wr_data = req_cell_is_wall;
         wr_addr = AW'(AW'(req_cell_row) * AW'(MAP_W)) + AW'(req_cell_col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_q_ff <= map_mem[rd_addr];
   end

   // lookup pipeline: candidate -> cell via reciprocal -> memory read
   logic signed [POS_W-1:0] cand_x, cand_y;
   logic [PIX_W-1:0]        pix_x, pix_y;
   logic                    lk1_vld_ff, lk2_vld_ff;
   grc_pkg::look_type       lk1_tag_ff, lk2_tag_ff;
   logic                    lk1_out_ff, lk2_out_ff;
   logic [PROD_W-1:0]       prod_x_ff, prod_y_ff;
   logic [CX_W-1:0]         cell_x;
   logic [CY_W-1:0]         cell_y;
   logic                    cur_wall_ff, wall3;

   assign cand_x = (cmd.look_tag == grc_pkg::LOOK_PX) ? x_ff - POS_W'(dx_ff) : x_ff;
   assign cand_y = (cmd.look_tag == grc_pkg::LOOK_PY) ? y_ff - POS_W'(dy_ff) : y_ff;
   assign pix_x  = cand_x[POS_W-1:14];
   assign pix_y  = cand_y[POS_W-1:14];
   assign cell_x = prod_x_ff[32 +: CX_W];
   assign cell_y = prod_y_ff[32 +: CY_W];
   assign rd_addr = AW'(AW'(cell_y) * AW'(MAP_W)) + AW'(cell_x);
   assign wall3  = lk2_out_ff | rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lk1_vld_ff <= 1'b0;
         lk2_vld_ff <= 1'b0;
      end else begin
         lk1_vld_ff <= cmd.look_en;
         lk2_vld_ff <= lk1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      lk1_tag_ff <= cmd.look_tag;
      lk1_out_ff <= cand_x[POS_W-1] | cand_y[POS_W-1]
                    | (32'(pix_x) >= LIM_X) | (32'(pix_y) >= LIM_Y);
      prod_x_ff  <= PROD_W'(16'(pix_x)) * PROD_W'(RECIP);
      prod_y_ff  <= PROD_W'(16'(pix_y)) * PROD_W'(RECIP);
      lk2_tag_ff <= lk1_tag_ff;
      lk2_out_ff <= lk1_out_ff;
      if (lk2_vld_ff) begin
         case (lk2_tag_ff)
            grc_pkg::LOOK_CUR: cur_wall_ff <= wall3;
            grc_pkg::LOOK_PX:  px_wall_ff  <= wall3;
            default:           py_wall_ff  <= wall3;
         endcase
      end
   end

   // distance: squares, bitwise integer square root
   logic signed [POS_W-1:0] diff_x, diff_y;
   logic [DIFF_W-1:0]       ax_ff, ay_ff;
   logic [SUM_W-1:0]        sq_ff, n_ff, r_ff, bit_ff, rb;
   logic [SUM_W-1:0]        dist_wide;
   logic [20:0]             dist_sat, dist_ff;

   assign diff_x = x_ff - ox;
   assign diff_y = y_ff - oy;
   assign rb     = r_ff + bit_ff;
   assign dist_wide = r_ff >> 6;
   assign dist_sat  = (dist_wide > SUM_W'(21'h1FFFFF)) ? 21'h1FFFFF : dist_wide[20:0];

   always_ff @(posedge clock) begin
      if (cmd.abs_diff) begin
         ax_ff <= DIFF_W'(diff_x[POS_W-1] ? -diff_x : diff_x);
         ay_ff <= DIFF_W'(diff_y[POS_W-1] ? -diff_y : diff_y);
      end
      if (cmd.sq_x) sq_ff <= SUM_W'(ax_ff) * SUM_W'(ax_ff);
      if (cmd.root_init) begin
         n_ff   <= sq_ff + SUM_W'(ay_ff) * SUM_W'(ay_ff);
         r_ff   <= '0;
         bit_ff <= SUM_W'(1) << (2 * (ROOT_W - 1));
      end else if (cmd.root_step) begin
         if (n_ff >= rb) begin
            n_ff <= n_ff - rb;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // height: restoring divide of the projection constant by distance*cos
   logic [REAL_W-1:0] real_ff, rem_ff;
   logic [REAL_W:0]   rem2;
   logic [DIV_W-1:0]  num_ff, quo_ff;
   logic              div_ge;

   assign rem2   = {rem_ff, num_ff[DIV_W-1]};
   assign div_ge = rem2 >= (REAL_W + 1)'(real_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         dist_ff <= dist_sat;
         real_ff <= REAL_W'(dist_sat) * REAL_W'(vc_ff);
         rem_ff  <= '0;
         num_ff  <= NUM;
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? REAL_W'(rem2 - (REAL_W + 1)'(real_ff)) : REAL_W'(rem2);
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
      end
   end

   // result assembly
   logic [15:0]        height;
   logic [16:0]        half_up;
   logic signed [18:0] span_s, span_e;
   logic [2:0]         face;
   logic signed [POS_W-1:0] qx, qy;
   logic [19:0]        hit_x, hit_y;

   always_comb begin
      if (nohit_ff) height = '0;
      else if (real_ff == '0 || quo_ff > DIV_W'(16'hFFFF)) height = 16'hFFFF;
      else height = quo_ff[15:0];
      half_up = (17'(height) + 17'd1) >> 1;
      span_s  = 19'(HALF) - 19'(half_up);
      if (span_s < 0) span_s = '0;
      span_e  = 19'(HALF) + 19'(height >> 1);
      if (span_e >= 19'(SCREEN_H)) span_e = 19'(SCREEN_H - 1);
      face = grc_pkg::FACE_NONE;
      if (!nohit_ff) begin
         if (probe_y_ff && dy_ff < 0) face = grc_pkg::FACE_WEST;
         else if (probe_y_ff && dy_ff > 0) face = grc_pkg::FACE_EAST;
         else if (probe_x_ff && dx_ff < 0) face = grc_pkg::FACE_SOUTH;
         else if (probe_x_ff && dx_ff > 0) face = grc_pkg::FACE_NORTH;
      end
      qx = x_ff >>> 6;
      qy = y_ff >>> 6;
      if (x_ff[POS_W-1]) hit_x = '0;
      else if (qx > POS_W'(20'hFFFFF)) hit_x = 20'hFFFFF;
      else hit_x = qx[19:0];
      if (y_ff[POS_W-1]) hit_y = '0;
      else if (qy > POS_W'(20'hFFFFF)) hit_y = 20'hFFFFF;
      else hit_y = qy[19:0];
   end

   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.publish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_out_column  <= column_ff;
         rsp_hit_x       <= hit_x;
         rsp_hit_y       <= hit_y;
         rsp_face        <= face;
         rsp_distance    <= dist_ff;
         rsp_wall_height <= height;
         rsp_span_start  <= span_s[8:0];
         rsp_span_end    <= span_e[8:0];
         rsp_no_hit      <= nohit_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.clear_done = clr_ff == AW'(DEPTH - 1);
   assign status.cur_wall   = cur_wall_ff;
   assign status.steps_max  = steps_ff == STEP_W'(MAX_STEPS);
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_ready;

endmodule

@@ rtl/grid_ray_caster_unit.sv @@
// grid_ray_caster_unit: top level of the grid ray caster.
// Depends on grc_pkg, grc_ctrl and grc_datapath.
//
//   channel  | direction | handshake           | contents
//   req_     | in        | req_valid/req_ready | map cell write or ray cast
//   rsp_     | out       | rsp_valid/rsp_ready | hit point, face, distance, span
//   csr_     | in        | csr_we              | ray origin x, ray origin y
//
// A cell write is stored as the request is accepted. A ray reads three map cells per march
// position (current, x probe, y probe) through one read port, over steps + 1 positions, then
// runs absolute differences, squares, bitwise square root, multiply, restoring divide and
// the result register before rsp_valid rises.
// After reset a clear sweep writes all MAP_W*MAP_H (4096) map cells to zero with req_ready low.
// One ray at a time; the next request is taken while a result waits on rsp_.
module grid_ray_caster_unit #(
   parameter int CELL_SIZE = 64,
   parameter int SCREEN_H  = 512,
   parameter int MAP_W     = 64,
   parameter int MAP_H     = 64,
   parameter int MAX_STEPS = 8192
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [5:0]          req_cell_col,
   input  logic [5:0]          req_cell_row,
   input  logic                req_cell_is_wall,
   input  logic [9:0]          req_column,
   input  logic signed [15:0]  req_step_x,
   input  logic signed [15:0]  req_step_y,
   input  logic [14:0]         req_view_cos,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [9:0]          rsp_out_column,
   output logic [19:0]         rsp_hit_x,
   output logic [19:0]         rsp_hit_y,
   output logic [2:0]          rsp_face,
   output logic [20:0]         rsp_distance,
   output logic [15:0]         rsp_wall_height,
   output logic [8:0]          rsp_span_start,
   output logic [8:0]          rsp_span_end,
   output logic                rsp_no_hit,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [19:0]         csr_wdata
);

   localparam int ROOT_W = $clog2(MAX_STEPS) + 17;
   localparam int DIV_W  = $clog2(CELL_SIZE * SCREEN_H + 1) + 22;

   grc_pkg::cmd_type    cmd;
   grc_pkg::status_type status;

   grc_ctrl #(
      .ROOT_W(ROOT_W),
      .DIV_W (DIV_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_mode),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   grc_datapath #(
      .CELL_SIZE(CELL_SIZE),
      .SCREEN_H (SCREEN_H),
      .MAP_W    (MAP_W),
      .MAP_H    (MAP_H),
      .MAX_STEPS(MAX_STEPS),
      .ROOT_W   (ROOT_W),
      .DIV_W    (DIV_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cell_col    (req_cell_col),
      .req_cell_row    (req_cell_row),
      .req_cell_is_wall(req_cell_is_wall),
      .req_column      (req_column),
      .req_step_x      (req_step_x),
      .req_step_y      (req_step_y),
      .req_view_cos    (req_view_cos),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_column  (rsp_out_column),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_face        (rsp_face),
      .rsp_distance    (rsp_distance),
      .rsp_wall_height (rsp_wall_height),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_no_hit      (rsp_no_hit)
   );

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ready)
      else $error("request taken during map clear");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten while pending");

   a_nohit_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_hit) |-> (rsp_face == grc_pkg::FACE_NONE && rsp_wall_height == 16'd0))
      else $error("no-hit result with face or height");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.set_nohit, cmd.publish, cmd.clear}))
      else $error("conflicting datapath commands");

endmodule
